/* hw/rtl/nws_pkg.sv */
// Shared constants, operation codes and transfer types of the weight splatting block.
package nws_pkg;

	// Default geometry and arithmetic settings.
	localparam int GRID_SIDE      = 4;
	localparam int FRACTION_BITS  = 20;
	localparam int MAX_WEIGHT_SUM = 256;

	// Fixed field widths.
	localparam int WEIGHT_W = 9;
	localparam int ACC_W    = 32;
	localparam int INT_W    = 16;

	// Operation codes carried in the operation field.
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_SPLAT = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Input transfer.
	typedef struct packed {
		logic [1:0]          operation;
		logic [1:0]          row;
		logic [1:0]          col;
		logic [WEIGHT_W-1:0] weight;
		logic [INT_W-1:0]    intensity;
	} in_item_t;

	// Result transfer.
	typedef struct packed {
		logic [1:0]       node_row;
		logic [1:0]       node_col;
		logic [ACC_W-1:0] count_value;
		logic [ACC_W-1:0] intensity_value;
		logic             sum_error;
		logic             last;
	} out_item_t;

endpackage

/* hw/rtl/nws_ram.sv */
// Generic single-write, single-read RAM with a registered, enable-held read port.
module nws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data holds while no read is enabled.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/normalized_weight_splat_core.sv */
// Top level of the normalized weight splatting block.
//
//   Channel | Handshake                 | Payload
//   --------+---------------------------+---------------------
//   input   | in_valid / in_stall       | in_data  (in_item_t)
//   result  | out_valid / out_stall     | out_data (out_item_t)
//
// A weight write reads the old weight, then writes the new one and adjusts the sum.
// A clear resets the accumulator valid bits. A splat with an oversized sum returns a single error result.
// A splat first forms the reciprocal of the weight sum in a bit-serial divider, then
// one node per cycle, while the result side does not stall, passes the read, scale,
// weight and write-back stages of the accumulator RAM, and the last node drains
// through them. A splat with a zero weight sum skips the divider.
// Reset clears valid bits held in flip-flops at once; no clearing pass is run.
// A stall on the result side freezes the node pipeline; items are taken one at a time.
module normalized_weight_splat_core #(
	parameter int GRID_SIDE      = nws_pkg::GRID_SIDE,       // 2 .. 4 with 2-bit indexes
	parameter int FRACTION_BITS  = nws_pkg::FRACTION_BITS,
	parameter int MAX_WEIGHT_SUM = nws_pkg::MAX_WEIGHT_SUM
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  nws_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output nws_pkg::out_item_t out_data
);

	localparam int NODES  = GRID_SIDE * GRID_SIDE;
	localparam int IDX_W  = $clog2(NODES);
	localparam int W_W    = nws_pkg::WEIGHT_W;
	localparam int ACC_W  = nws_pkg::ACC_W;
	localparam int INT_W  = nws_pkg::INT_W;
	localparam int SUM_W  = $clog2(NODES * ((1 << W_W) - 1) + 1);
	localparam int REC_W  = FRACTION_BITS + 1;
	localparam int STEP_W = $clog2(REC_W);
	localparam int MUL_W  = W_W + REC_W;
	localparam int PROD_W = ACC_W + INT_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WUPD,
		ST_DIV,
		ST_RUN,
		ST_DRAIN,
		ST_ERR
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   idx_q;
	logic [1:0]         row_q;
	logic [1:0]         col_q;
	logic [STEP_W-1:0]  step_q;
	logic [SUM_W-1:0]   rem_q;
	logic [REC_W-1:0]   dvd_q;
	logic [SUM_W-1:0]   sum_q;
	logic [NODES-1:0]   w_vld_q;
	logic [NODES-1:0]   acc_vld_q;
	logic               out_valid_q;
	nws_pkg::out_item_t out_data_q;
	logic [IDX_W-1:0]   waddr_q;
	logic [W_W-1:0]     wnew_q;
	logic [INT_W-1:0]   intensity_q;

	// Node pipeline registers.
	logic               v_s1, v_s2, v_s3;
	logic [IDX_W-1:0]   idx_s1, idx_s2, idx_s3;
	logic [1:0]         row_s1, row_s2, row_s3;
	logic [1:0]         col_s1, col_s2, col_s3;
	logic               last_s1, last_s2, last_s3;
	logic [ACC_W-1:0]   norm_s2;
	logic [ACC_W-1:0]   cnt_s2, cnt_s3;
	logic [ACC_W-1:0]   int_s2, int_s3;
	logic [ACC_W-1:0]   prod_s3;

	logic               accept;
	logic               adv;
	logic               issue;
	logic               out_load;
	logic               in_grid;
	logic [IDX_W-1:0]   in_idx;
	logic [IDX_W-1:0]   node_last;
	logic [SUM_W:0]     trial;
	logic [SUM_W:0]     diff;
	logic               ge;
	logic [W_W-1:0]     w_rdata;
	logic [W_W-1:0]     w_old;
	logic [W_W-1:0]     w_eff;
	logic [2*ACC_W-1:0] acc_rdata;
	logic [2*ACC_W-1:0] acc_wdata;
	logic [ACC_W-1:0]   cnt_rd;
	logic [ACC_W-1:0]   int_rd;
	logic [ACC_W-1:0]   int_new;
	logic [MUL_W-1:0]   mul_full;
	logic [PROD_W-1:0]  prod_full;
	logic               w_re;
	logic [IDX_W-1:0]   w_raddr;
	logic               acc_we;

	// Handshake and pipeline advance.
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign adv      = !out_valid_q || !out_stall;
	assign issue    = (state_q == ST_RUN) && adv;

	// A new result transfer is loaded into the output register this cycle.
	assign out_load = acc_we || ((state_q == ST_ERR) && adv);

	// Node address of a weight write and its range check.
	assign in_grid   = ({1'b0, in_data.row} < 3'(GRID_SIDE)) &&
	                   ({1'b0, in_data.col} < 3'(GRID_SIDE));
	assign in_idx    = IDX_W'(int'(in_data.row) * GRID_SIDE + int'(in_data.col));
	assign node_last = IDX_W'(NODES - 1);

	// One restoring division step of the reciprocal.
	assign trial = {rem_q, dvd_q[REC_W-1]};
	assign ge    = (trial >= {1'b0, sum_q});
	assign diff  = trial - {1'b0, sum_q};

	// Weight RAM: read for the node loop or for the old value of a weight write.
	assign w_re    = (state_q == ST_RUN) ? issue : accept;
	assign w_raddr = (state_q == ST_RUN) ? idx_q : in_idx;
	assign w_old   = w_vld_q[waddr_q] ? w_rdata : '0;

	nws_ram #(
		.WIDTH(W_W),
		.DEPTH(NODES)
	) u_weight_ram (
		.clk  (clk),
		.we   (state_q == ST_WUPD),
		.waddr(waddr_q),
		.wdata(wnew_q),
		.re   (w_re),
		.raddr(w_raddr),
		.rdata(w_rdata)
	);

	// Accumulator RAM: count in the upper half, intensity in the lower half.
	assign acc_we    = adv && v_s3;
	assign int_new   = int_s3 + prod_s3;
	assign acc_wdata = {cnt_s3, int_new};

	nws_ram #(
		.WIDTH(2 * ACC_W),
		.DEPTH(NODES)
	) u_acc_ram (
		.clk  (clk),
		.we   (acc_we),
		.waddr(idx_s3),
		.wdata(acc_wdata),
		.re   (issue),
		.raddr(idx_q),
		.rdata(acc_rdata)
	);

	// Entries never written since reset (accumulators also since a clear) read as zero.
	assign w_eff  = w_vld_q[idx_s1] ? w_rdata : '0;
	assign cnt_rd = acc_vld_q[idx_s1] ? acc_rdata[2*ACC_W-1:ACC_W] : '0;
	assign int_rd = acc_vld_q[idx_s1] ? acc_rdata[ACC_W-1:0] : '0;

	// Scale the weight by the reciprocal, then the normalized weight by the intensity.
	assign mul_full  = MUL_W'(w_eff) * MUL_W'(dvd_q);
	assign prod_full = PROD_W'(norm_s2) * PROD_W'(intensity_q);

	// Control sequencer, running weight sum, divider and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			step_q      <= '0;
			rem_q       <= '0;
			dvd_q       <= '0;
			sum_q       <= '0;
			w_vld_q     <= '0;
			acc_vld_q   <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			waddr_q     <= '0;
			wnew_q      <= '0;
			intensity_q <= '0;
		end else begin
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_data.operation)
							nws_pkg::OP_WRITE: begin
								if (in_grid) begin
									waddr_q <= in_idx;
									wnew_q  <= in_data.weight;
									state_q <= ST_WUPD;
								end
							end
							nws_pkg::OP_SPLAT: begin
								intensity_q <= in_data.intensity;
								idx_q       <= '0;
								row_q       <= '0;
								col_q       <= '0;
								if (sum_q > SUM_W'(MAX_WEIGHT_SUM)) begin
									state_q <= ST_ERR;
								end else if (sum_q == '0) begin
									// All weights are zero, so every scaled weight is zero.
									dvd_q   <= '0;
									state_q <= ST_RUN;
								end else begin
									rem_q   <= '0;
									dvd_q   <= REC_W'(1 << FRACTION_BITS) +
									           REC_W'(sum_q >> 1);
									step_q  <= STEP_W'(REC_W - 1);
									state_q <= ST_DIV;
								end
							end
							nws_pkg::OP_CLEAR: begin
								acc_vld_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_WUPD: begin
					sum_q            <= sum_q - SUM_W'(w_old) + SUM_W'(wnew_q);
					w_vld_q[waddr_q] <= 1'b1;
					state_q          <= ST_IDLE;
				end
				ST_DIV: begin
					rem_q <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
					dvd_q <= {dvd_q[REC_W-2:0], ge};
					if (step_q == '0) begin
						state_q <= ST_RUN;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_RUN: begin
					if (adv) begin
						idx_q <= idx_q + 1'b1;
						if (col_q == 2'(GRID_SIDE - 1)) begin
							col_q <= '0;
							row_q <= row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
						if (idx_q == node_last) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ERR: begin
					if (adv) begin
						out_valid_q <= 1'b1;
						out_data_q  <= '{node_row: 2'd0, node_col: 2'd0, count_value: '0,
						                 intensity_value: '0, sum_error: 1'b1, last: 1'b1};
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Write-back stage: the updated node becomes the next result transfer.
			if (acc_we) begin
				acc_vld_q[idx_s3]          <= 1'b1;
				out_valid_q                <= 1'b1;
				out_data_q.node_row        <= row_s3;
				out_data_q.node_col        <= col_s3;
				out_data_q.count_value     <= cnt_s3;
				out_data_q.intensity_value <= int_new;
				out_data_q.sum_error       <= 1'b0;
				out_data_q.last            <= last_s3;
			end
		end
	end

	// Stage valid bits of the node pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage payloads of the node pipeline.
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1  <= idx_q;
			row_s1  <= row_q;
			col_s1  <= col_q;
			last_s1 <= (idx_q == node_last);

			idx_s2  <= idx_s1;
			row_s2  <= row_s1;
			col_s2  <= col_s1;
			last_s2 <= last_s1;
			norm_s2 <= ACC_W'(mul_full);
			cnt_s2  <= cnt_rd;
			int_s2  <= int_rd;

			idx_s3  <= idx_s2;
			row_s3  <= row_s2;
			col_s3  <= col_s2;
			last_s3 <= last_s2;
			cnt_s3  <= cnt_s2 + norm_s2;
			int_s3  <= int_s2;
			prod_s3 <= prod_full[ACC_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
